// File: sv/bounded_deque_with_positional_ops_defines.svh
// Assertion macros used by the checker of the bounded deque.
`ifndef BOUNDED_DEQUE_WITH_POSITIONAL_OPS_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_POSITIONAL_OPS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/bdq_pkg.sv
// Package with the types and constants of the bounded deque.
`default_nettype none

package bdq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [2:0] {
      OP_PUSH_TAIL = 3'd0,
      OP_PUSH_HEAD = 3'd1,
      OP_INSERT_AT = 3'd2,
      OP_POP_TAIL  = 3'd3,
      OP_POP_HEAD  = 3'd4,
      OP_DELETE_AT = 3'd5,
      OP_FIND_MIN  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_POS   = 2'd3
   } status_type;

   typedef struct packed {
      op_type           operation;
      word_type         data_value;
      logic [CNT_W-1:0] position;
   } req_type;

   typedef struct packed {
      word_type         result_value;
      logic [IDX_W-1:0] result_position;
      logic [CNT_W-1:0] entry_count;
      logic             is_empty;
      status_type       status;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_REPLY
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic scan_init;
      logic scan_step;
      logic min_finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic min_go;
      logic scan_done;
   } dp_status_type;

endpackage

`default_nettype wire

// File: sv/bdq_ctrl.sv
// Controller state machine that sequences each command of the bounded deque.
`default_nettype none

module bdq_ctrl
   import bdq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dp_status_type dp_status,
   output ctl_cmd_type        cmd,
   output logic               busy,
   output logic               rsp_strobe
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (dp_status.min_go) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_REPLY;
            end
         end
         S_SCAN: begin
            if (dp_status.scan_done) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         S_EXEC: begin
            cmd.exec      = !dp_status.min_go;
            cmd.scan_init = dp_status.min_go;
         end
         S_SCAN: begin
            cmd.scan_step  = !dp_status.scan_done;
            cmd.min_finish = dp_status.scan_done;
         end
         S_REPLY: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/bdq_datapath.sv
// Datapath of the bounded deque: storage cells, shifting, minimum scan and result word.
`default_nettype none

module bdq_datapath
   import bdq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req_data,
   input  wire ctl_cmd_type cmd,
   output dp_status_type    dp_status,
   output rsp_type          rsp_data
);

   req_type          req_ff;
   word_type         cells_ff [DEPTH];
   word_type         cells_in [DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] scan_ff;
   word_type         min_val_ff;
   logic [IDX_W-1:0] min_pos_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic             is_full;
   logic             is_none;
   logic             do_ins;
   logic             do_del;
   logic             min_go;
   logic [CNT_W-1:0] ins_pos;
   logic [CNT_W-1:0] del_pos;
   status_type       op_status;
   word_type         del_word;
   word_type         scan_word;

   // Decode the held command against the current fill level.
   always_comb begin
      is_full   = (count_ff == CNT_W'(DEPTH));
      is_none   = (count_ff == '0);
      do_ins    = 1'b0;
      do_del    = 1'b0;
      min_go    = 1'b0;
      ins_pos   = '0;
      del_pos   = '0;
      op_status = ST_OK;
      case (req_ff.operation)
         OP_PUSH_TAIL, OP_PUSH_HEAD, OP_INSERT_AT: begin
            if (is_full) begin
               op_status = ST_FULL;
            end else if (req_ff.operation == OP_PUSH_TAIL) begin
               do_ins  = 1'b1;
               ins_pos = count_ff;
            end else if (req_ff.operation == OP_PUSH_HEAD) begin
               do_ins  = 1'b1;
               ins_pos = '0;
            end else if (req_ff.position > count_ff) begin
               op_status = ST_POS;
            end else begin
               do_ins  = 1'b1;
               ins_pos = req_ff.position;
            end
         end
         OP_POP_TAIL, OP_POP_HEAD, OP_DELETE_AT: begin
            if (is_none) begin
               op_status = ST_EMPTY;
            end else if (req_ff.operation == OP_POP_TAIL) begin
               do_del  = 1'b1;
               del_pos = count_ff - CNT_W'(1);
            end else if (req_ff.operation == OP_POP_HEAD) begin
               do_del  = 1'b1;
               del_pos = '0;
            end else if (req_ff.position >= count_ff) begin
               op_status = ST_POS;
            end else begin
               do_del  = 1'b1;
               del_pos = req_ff.position;
            end
         end
         OP_FIND_MIN: begin
            if (is_none) begin
               op_status = ST_EMPTY;
            end else begin
               min_go = 1'b1;
            end
         end
         default: begin
            op_status = ST_OK;
         end
      endcase
   end

   assign del_word  = cells_ff[del_pos[IDX_W-1:0]];
   assign scan_word = cells_ff[scan_ff[IDX_W-1:0]];

   assign dp_status.min_go    = min_go;
   assign dp_status.scan_done = (scan_ff >= count_ff);

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // A cell holds, takes the new word or left neighbor on insert, or right neighbor on delete.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      localparam int PREV = (g == 0) ? 0 : g - 1;
      localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;
      always_comb begin
         cells_in[g] = cells_ff[g];
         if (do_ins) begin
            if (CNT_W'(g) == ins_pos) begin
               cells_in[g] = req_ff.data_value;
            end else if (CNT_W'(g) > ins_pos) begin
               cells_in[g] = cells_ff[PREV];
            end
         end else if (do_del) begin
            if (CNT_W'(g) >= del_pos) begin
               cells_in[g] = cells_ff[NEXT];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         for (int i = 0; i < DEPTH; i++) begin
            cells_ff[i] <= cells_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // The minimum scan visits one cell per cycle; ties keep the lower index.
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         min_val_ff <= cells_ff[0];
         min_pos_ff <= '0;
         scan_ff    <= CNT_W'(1);
      end else if (cmd.scan_step) begin
         if (scan_word < min_val_ff) begin
            min_val_ff <= scan_word;
            min_pos_ff <= scan_ff[IDX_W-1:0];
         end
         scan_ff <= scan_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.exec) begin
         rsp_in.result_value    = do_del ? del_word : '0;
         rsp_in.result_position = do_del ? del_pos[IDX_W-1:0] : '0;
         rsp_in.entry_count     = count_in;
         rsp_in.is_empty        = (count_in == '0);
         rsp_in.status          = op_status;
      end else if (cmd.min_finish) begin
         rsp_in.result_value    = min_val_ff;
         rsp_in.result_position = min_pos_ff;
         rsp_in.entry_count     = count_ff;
         rsp_in.is_empty        = (count_ff == '0);
         rsp_in.status          = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: sv/bounded_deque_with_positional_ops.sv
// Top level of the bounded deque with positional insert, delete and minimum search.
`default_nettype none

// A word is accepted when start is high and busy is low; busy stays high until the
// result has been shown. Push, pop, insert and delete pass through the accept, a step
// in which the cells from the given position on shift in parallel if the command is
// valid, and a step in which the result is shown. Find minimum holds busy after the
// accept through an execute step, a scan in which a single comparator steps through
// the stored words one per cycle, and the step that shows the result. Each result is
// marked on rsp_data by rsp_strobe, high for exactly one cycle, and the receiver
// cannot hold it off. Every command gives exactly one result.

module bounded_deque_with_positional_ops
   import bdq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .dp_status  (dp_status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   bdq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: sv/bdq_checker.sv
// Port checker for the bounded deque and the bind that attaches it.
`default_nettype none
`include "bounded_deque_with_positional_ops_defines.svh"

module bdq_checker
   import bdq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   `BDQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_strobe,
      "accepted word did not raise busy")
   `BDQ_ASSERT_NOW(a_strobe_busy, clock, reset, rsp_strobe, busy,
      "result shown while not busy")
   `BDQ_ASSERT_NEXT(a_strobe_once, clock, reset, rsp_strobe, !rsp_strobe && !busy,
      "result shown longer than one cycle")
   `BDQ_ASSERT_NOW(a_count_sane, clock, reset, rsp_strobe,
      (rsp_data.entry_count <= CNT_W'(DEPTH)) &&
      (rsp_data.is_empty == (rsp_data.entry_count == '0)),
      "entry count and empty flag disagree")

endmodule

bind bounded_deque_with_positional_ops bdq_checker u_bdq_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench of the bounded deque with positional insert, delete and minimum search.
module testbench
   import bdq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam op_type OP_NO_ACTION = op_type'(3'd7);
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 700;
   localparam int MODE_FILL = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;

   req_type pending_commands[$];
   rsp_type expected_replies[$];
   rsp_type want_reply;

   word_type held_words[DEPTH];
   int held_count = 0;

   int gap_left = 0;
   int calm_left = 0;
   int idle_cycles = 0;
   int fail_count = 0;

   bounded_deque_with_positional_ops i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type apply_command(req_type cmd);
      rsp_type reply;
      int slot;
      reply = '0;
      reply.status = ST_OK;
      case (cmd.operation)
         OP_PUSH_TAIL, OP_PUSH_HEAD, OP_INSERT_AT: begin
            if (held_count >= DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               if (cmd.operation == OP_PUSH_TAIL) slot = held_count;
               else if (cmd.operation == OP_PUSH_HEAD) slot = 0;
               else slot = int'(cmd.position);
               if (slot > held_count) begin
                  reply.status = ST_POS;
               end else begin
                  for (int i = held_count; i > slot; i--) held_words[i] = held_words[i-1];
                  held_words[slot] = cmd.data_value;
                  held_count++;
               end
            end
         end
         OP_POP_TAIL, OP_POP_HEAD, OP_DELETE_AT: begin
            if (held_count == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               if (cmd.operation == OP_POP_TAIL) slot = held_count - 1;
               else if (cmd.operation == OP_POP_HEAD) slot = 0;
               else slot = int'(cmd.position);
               if (slot >= held_count) begin
                  reply.status = ST_POS;
               end else begin
                  reply.result_value = held_words[slot];
                  reply.result_position = IDX_W'(slot);
                  for (int i = slot; i + 1 < held_count; i++) held_words[i] = held_words[i+1];
                  held_count--;
               end
            end
         end
         OP_FIND_MIN: begin
            if (held_count == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               reply.result_value = held_words[0];
               for (int i = 1; i < held_count; i++) begin
                  if (held_words[i] < reply.result_value) begin
                     reply.result_value = held_words[i];
                     reply.result_position = IDX_W'(i);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      reply.entry_count = CNT_W'(held_count);
      reply.is_empty = (held_count == 0);
      return reply;
   endfunction

   function automatic int next_gap();
      int pick;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   task automatic add_command(op_type op, word_type value, int pos);
      req_type cmd;
      cmd.operation = op;
      cmd.data_value = value;
      cmd.position = CNT_W'(pos);
      pending_commands.push_back(cmd);
   endtask

   task automatic add_random_command(int mode);
      int pick;
      int add_share;
      op_type op;
      word_type value;
      int pos;
      if (mode == MODE_FILL) add_share = 78;
      else if (mode == MODE_DRAIN) add_share = 25;
      else add_share = 50;
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_NO_ACTION;
      else if (pick < add_share) op = op_type'($urandom_range(0, 2));
      else op = op_type'($urandom_range(3, 6));
      pick = $urandom_range(0, 99);
      if (pick < 40) value = word_type'($urandom);
      else if (pick < 75) value = word_type'(int'($urandom_range(0, 15)) - 8);
      else begin
         case ($urandom_range(0, 3))
            0: value = word_type'(32'h7FFF_FFFF);
            1: value = word_type'(32'h8000_0000);
            2: value = '0;
            default: value = '1;
         endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) pos = $urandom_range(0, 16);
      else if (pick < 90) pos = $urandom_range(0, 3);
      else pos = $urandom_range(0, 31);
      add_command(op, value, pos);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            expected_replies.push_back(apply_command(req_data));
            gap_left = next_gap();
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_commands.size() > 0) begin
            req_data <= pending_commands.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(string field, longint want, longint got);
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_replies.size() == 0) begin
            $error("result word with no command outstanding");
            fail_count++;
         end else begin
            want_reply = expected_replies.pop_front();
            if (rsp_data.result_value !== want_reply.result_value)
               report_mismatch("result_value", want_reply.result_value, rsp_data.result_value);
            if (rsp_data.result_position !== want_reply.result_position)
               report_mismatch("result_position", want_reply.result_position,
                  rsp_data.result_position);
            if (rsp_data.entry_count !== want_reply.entry_count)
               report_mismatch("entry_count", want_reply.entry_count, rsp_data.entry_count);
            if (rsp_data.is_empty !== want_reply.is_empty)
               report_mismatch("is_empty", want_reply.is_empty, rsp_data.is_empty);
            if (rsp_data.status !== want_reply.status)
               report_mismatch("status", want_reply.status, rsp_data.status);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      add_command(OP_POP_TAIL, '0, 0);
      add_command(OP_POP_HEAD, '0, 0);
      add_command(OP_DELETE_AT, '0, 0);
      add_command(OP_FIND_MIN, '0, 0);
      add_command(OP_NO_ACTION, '1, 31);
      add_command(OP_INSERT_AT, 32'sd5, 1);
      add_command(OP_INSERT_AT, word_type'(32'h8000_0000), 0);
      add_command(OP_POP_TAIL, '0, 0);
      add_command(OP_PUSH_HEAD, 32'sd7, 0);
      add_command(OP_POP_HEAD, '0, 0);
      add_command(OP_PUSH_TAIL, word_type'(32'h7FFF_FFFF), 0);
      add_command(OP_PUSH_HEAD, word_type'(32'h8000_0000), 0);
      add_command(OP_INSERT_AT, '1, 1);
      add_command(OP_INSERT_AT, '0, 3);
      add_command(OP_INSERT_AT, 32'sd9, 31);
      add_command(OP_DELETE_AT, '0, 4);
      add_command(OP_DELETE_AT, '0, 31);
      add_command(OP_FIND_MIN, '0, 0);
      add_command(OP_PUSH_TAIL, word_type'(32'h8000_0000), 16);
      add_command(OP_FIND_MIN, '0, 0);
      add_command(OP_DELETE_AT, '0, 1);
      add_command(OP_POP_TAIL, '0, 0);
      add_command(OP_POP_HEAD, '0, 0);
      add_command(OP_FIND_MIN, '0, 0);
      add_command(OP_NO_ACTION, '0, 0);
      for (int n = 0; n < RANDOM_ITEMS; n += 35) begin
         int mode;
         mode = $urandom_range(MODE_FILL, MODE_MIXED);
         for (int k = 0; k < 35; k++) add_random_command(mode);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (pending_commands.size() > 0 || start || expected_replies.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/bdq_pkg.sv
sv/bdq_ctrl.sv
sv/bdq_datapath.sv
sv/bounded_deque_with_positional_ops.sv
sv/bdq_checker.sv
sim/testbench.sv
